### rtl/dlkd_pkg.sv
// shared types and constants of the duplicate link key detector
`timescale 1ns / 1ps
package dlkd_pkg;
   localparam int SRC_W = 15;
   localparam int DST_W = 15;
   localparam int ACT_W = 8;
   localparam int KEY_W = SRC_W + DST_W + ACT_W;
   localparam int POS_W = 8;

   typedef logic [KEY_W-1:0] key_type;

   // one classified link word as it travels from front to back
   typedef struct packed {
      key_type key;
      logic    last;
   } item_type;
endpackage

### rtl/dlkd_ifs.sv
// channel interfaces for link words and result words
`timescale 1ns / 1ps
interface dlkd_req_if import dlkd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SRC_W-1:0] link_source;
   logic [DST_W-1:0] link_destination;
   logic [ACT_W-1:0] link_action;
   logic             is_last;
   modport source (output valid, link_source, link_destination, link_action, is_last,
                   input ready);
   modport sink (input valid, link_source, link_destination, link_action, is_last,
                 output ready);
endinterface

interface dlkd_rsp_if import dlkd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             duplicate_found;
   logic [POS_W-1:0] duplicate_position;
   logic             overflowed;
   modport source (output valid, duplicate_found, duplicate_position, overflowed,
                   input ready);
   modport sink (input valid, duplicate_found, duplicate_position, overflowed,
                 output ready);
endinterface

### rtl/dlkd_front.sv
// front stage: takes link words and forms the identity key
`timescale 1ns / 1ps
module dlkd_front import dlkd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   dlkd_req_if.sink req,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_ready
);
   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req.ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         valid_in      = 1'b1;
         item_in.key   = {req.link_source, req.link_destination, req.link_action};
         item_in.last  = req.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end
endmodule

### rtl/dlkd_queue.sv
// short fifo between front and back
`timescale 1ns / 1ps
module dlkd_queue import dlkd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop_ready
);
   localparam int DEPTH = 4;
   localparam int PW    = 2;

   item_type        slots [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]     fill_ff, fill_in;
   logic            do_push, do_pop;

   assign push_ready = fill_ff != (PW+1)'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_item   = slots[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         slots[wr_ff] <= push_item;
      end
   end
endmodule

### rtl/dlkd_back.sv
// back part: key store, duplicate scan and result register
`timescale 1ns / 1ps
module dlkd_back import dlkd_pkg::*; #(
   parameter int MAX_LINKS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  item_type   in_item,
   output logic       in_ready,
   dlkd_rsp_if.source rsp
);
   localparam int AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int CW = $clog2(MAX_LINKS + 1);

   typedef enum logic [2:0] {S_LOAD, S_GET_J, S_LATCH_J, S_COMPARE, S_RESULT} state_type;

   key_type       mem [MAX_LINKS];
   key_type       rd_data_ff;
   logic [AW-1:0] rd_addr;

   state_type     state_ff;
   logic [CW-1:0] count_ff, j_ff, i_ff;
   logic          ovf_ff, found_ff;
   key_type       kj_ff, best_ff;
   logic [AW-1:0] best_pos_ff;
   logic          rsp_valid_ff, rsp_found_ff, rsp_ovf_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic [AW+POS_W-1:0] pos_ext;
   logic          take, room;

   assign in_ready = state_ff == S_LOAD;
   assign take     = in_valid && in_ready;
   assign room     = count_ff != CW'(MAX_LINKS);
   assign pos_ext  = {{POS_W{1'b0}}, best_pos_ff};

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.duplicate_found    = rsp_found_ff;
   assign rsp.duplicate_position = rsp_pos_ff;
   assign rsp.overflowed         = rsp_ovf_ff;

   always_comb begin
      case (state_ff)
         S_GET_J:   rd_addr = j_ff[AW-1:0];
         S_LATCH_J: rd_addr = '0;
         S_COMPARE: rd_addr = i_ff[AW-1:0];
         default:   rd_addr = j_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (take && room) begin
         mem[count_ff[AW-1:0]] <= in_item.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (take) begin
                  if (room) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (in_item.last) begin
                     found_ff <= 1'b0;
                     j_ff     <= CW'(1);
                     if ((room ? count_ff + 1'b1 : count_ff) < CW'(2)) begin
                        state_ff <= S_RESULT;
                     end else begin
                        state_ff <= S_GET_J;
                     end
                  end
               end
            end
            S_GET_J: state_ff <= S_LATCH_J;
            S_LATCH_J: begin
               kj_ff    <= rd_data_ff;
               i_ff     <= CW'(1);
               state_ff <= S_COMPARE;
            end
            S_COMPARE: begin
               if (rd_data_ff == kj_ff || i_ff == j_ff) begin
                  if (rd_data_ff == kj_ff && (!found_ff || kj_ff < best_ff)) begin
                     found_ff    <= 1'b1;
                     best_ff     <= kj_ff;
                     best_pos_ff <= j_ff[AW-1:0];
                  end
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= (j_ff + 1'b1 == count_ff) ? S_RESULT : S_GET_J;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_pos_ff   <= found_ff ? pos_ext[POS_W-1:0] : '0;
                  rsp_ovf_ff   <= ovf_ff;
               end else if (rsp.ready) begin
                  rsp_valid_ff <= 1'b0;
                  count_ff     <= '0;
                  ovf_ff       <= 1'b0;
                  state_ff     <= S_LOAD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end
endmodule

### rtl/duplicate_link_key_detector.sv
// top level of the duplicate link key detector
//
//   channel | dir | contents
//   req     | in  | link_source, link_destination, link_action, is_last
//   rsp     | out | duplicate_found, duplicate_position, overflowed
//
// a link word is accepted every cycle while the back part is loading
// the word marked last starts a pairwise scan of the key store through its
// single read port, comparing each stored key with every earlier one, and
// ends by forming the result word
// reset is synchronous; the store itself is never cleared
// a stalled rsp holds the back part; the queue lets the front take words until it is full
`timescale 1ns / 1ps
module duplicate_link_key_detector import dlkd_pkg::*; #(
   parameter int MAX_LINKS = 256
) (
   input  logic       clock,
   input  logic       reset,
   dlkd_req_if.sink   req,
   dlkd_rsp_if.source rsp
);
   // front to queue
   logic     f_valid, f_ready;
   item_type f_item;
   // queue to back
   logic     b_valid, b_ready;
   item_type b_item;

   dlkd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_ready (f_ready)
   );

   dlkd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_item  (f_item),
      .push_ready (f_ready),
      .pop_valid  (b_valid),
      .pop_item   (b_item),
      .pop_ready  (b_ready)
   );

   // key store, duplicate scan and result register
   dlkd_back #(.MAX_LINKS(MAX_LINKS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b_valid),
      .in_item  (b_item),
      .in_ready (b_ready),
      .rsp      (rsp)
   );
endmodule

### rtl/dlkd_checker.sv
// port checks on the result channel and their binding
`timescale 1ns / 1ps
module dlkd_checker import dlkd_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_found,
   input logic [POS_W-1:0] rsp_pos
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_nodup_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_pos == '0)
      else $error("position set without duplicate");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("second result word without a batch");
endmodule

bind duplicate_link_key_detector dlkd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_found (rsp.duplicate_found),
   .rsp_pos   (rsp.duplicate_position)
);
